// File: hdl/tsw_pkg.sv
// Shared types and constants for the texture sampler with wrap modes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package tsw_pkg;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int ADDR_IN_W  = 16;
    localparam int TEXEL_W    = 32;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Default sizes
    localparam int MAX_DIM_DEF     = 256;
    localparam int STORE_WORDS_DEF = 65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd4;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] DIM_RST = 9'd256;

    // Item function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Coordinate handling; the unused code behaves as mirror
    localparam logic [1:0] WRAP_CLAMP    = 2'd0;
    localparam logic [1:0] WRAP_PERIODIC = 2'd1;
    localparam logic [1:0] WRAP_MIRROR   = 2'd2;
    localparam logic [1:0] WRAP_MIRROR_ALT = 2'd3;

    // Filter
    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;

    // Control to a coordinate unit
    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } tsw_axis_ctl_t;

endpackage

// File: hdl/tsw_if.sv
// Handshake channels of the texture sampler: input items and result words.
// Depends on tsw_pkg for field widths.
`timescale 1ns / 1ps

interface tsw_in_if;
    import tsw_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ADDR_IN_W-1:0]        write_addr;
    logic [TEXEL_W-1:0]          texel_rgba;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;

    modport source (output valid, func, write_addr, texel_rgba, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, func, write_addr, texel_rgba, coord_x, coord_y,
                    output ready);
endinterface

interface tsw_out_if;
    import tsw_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// File: hdl/tsw_store.sv
// Texel memory: single port, synchronous, registered read.
// Depends on tsw_pkg for the texel width.
`timescale 1ns / 1ps

module tsw_store #(
    parameter int DEPTH = tsw_pkg::STORE_WORDS_DEF,
    parameter int AW    = $clog2(tsw_pkg::STORE_WORDS_DEF)
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [tsw_pkg::TEXEL_W-1:0] wdata,
    output logic [tsw_pkg::TEXEL_W-1:0] rdata
);
    import tsw_pkg::*;

    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tsw_axis.sv
// Coordinate unit for one axis: clamp, periodic wrap or mirror of a Q16.8 value.
// Reduces the integer part by the dimension one quotient bit per cycle.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_axis #(
    parameter int MAX_DIM = tsw_pkg::MAX_DIM_DEF,
    parameter int CW      = $clog2(tsw_pkg::MAX_DIM_DEF) + 1,
    parameter int FW      = $clog2(tsw_pkg::MAX_DIM_DEF) + 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tsw_pkg::tsw_axis_ctl_t             ctl,
    input  logic signed [tsw_pkg::COORD_W-1:0] coord,
    input  logic [CW-1:0]                      dim,
    output logic                               done,
    output logic [FW-1:0]                      fpos
);
    import tsw_pkg::*;

    localparam int NQ  = COORD_W - FRAC_W;
    localparam int NCW = $clog2(NQ);

    logic               busy_reg, fin_reg, done_reg;
    logic [NCW-1:0]     cnt_reg;
    logic               neg_reg, qbit_reg;
    logic [1:0]         mode_reg;
    logic [COORD_W-1:0] mag_reg;
    logic [NQ-1:0]      num_reg;
    logic [CW-1:0]      rem_reg;
    logic [FW-1:0]      fpos_reg, fpos_next;
    logic [COORD_W-1:0] mag_in;
    logic [CW:0]        trial;
    logic               fits;
    logic [FW-1:0]      m, lastf;
    logic [CW+7:0]      span;
    logic [CW-1:0]      dim_m1;

    assign mag_in = coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
    assign trial  = {rem_reg, num_reg[NQ-1]};
    assign fits   = trial >= {1'b0, dim};
    assign dim_m1 = dim - CW'(1);
    assign m      = {rem_reg[FW-9:0], mag_reg[FRAC_W-1:0]};
    assign lastf  = {dim_m1[FW-9:0], 8'd0};
    assign span   = {dim, 8'd0};

    always_comb
    begin
        unique case (mode_reg)
            WRAP_CLAMP:
            begin
                if (neg_reg)
                    fpos_next = '0;
                else if (mag_reg > COORD_W'(lastf))
                    fpos_next = lastf;
                else
                    fpos_next = FW'(mag_reg);
            end
            WRAP_PERIODIC:
            begin
                if (neg_reg && m != '0)
                    fpos_next = FW'(span - (CW+8)'(m));
                else
                    fpos_next = m;
            end
            WRAP_MIRROR, WRAP_MIRROR_ALT:
            begin
                // odd periods reflect; a reflection below zero pins at zero
                if (!qbit_reg)
                    fpos_next = m;
                else if (m > lastf)
                    fpos_next = '0;
                else
                    fpos_next = lastf - m;
            end
            default: fpos_next = m;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= coord[COORD_W-1];
                mode_reg <= ctl.mode;
                mag_reg  <= mag_in;
                num_reg  <= mag_in[COORD_W-1:FRAC_W];
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? CW'(trial - {1'b0, dim}) : CW'(trial);
                qbit_reg <= fits;
                num_reg  <= num_reg << 1;
                cnt_reg  <= cnt_reg + NCW'(1);
                if (cnt_reg == NCW'(NQ - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fpos_reg <= fpos_next;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign fpos = fpos_reg;

endmodule

// File: hdl/tsw_lerp.sv
// Four-channel byte lerp of two texels by an 8-bit weight, rounded to bytes.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_lerp (
    input  logic [tsw_pkg::TEXEL_W-1:0] a,
    input  logic [tsw_pkg::TEXEL_W-1:0] b,
    input  logic [7:0]                  t,
    output logic [tsw_pkg::TEXEL_W-1:0] y
);
    import tsw_pkg::*;

    logic [8:0] wa;

    assign wa = 9'd256 - {1'b0, t};

    for (genvar k = 0; k < 4; k++)
    begin : g_ch
        logic [16:0] s;
        assign s = 17'(a[k*CH_W +: CH_W]) * 17'(wa)
                 + 17'(b[k*CH_W +: CH_W]) * 17'(t) + 17'd128;
        assign y[k*CH_W +: CH_W] = s[15:8];
    end

endmodule

// File: hdl/texture_sampler_wrap_bilinear.sv
// Texture sampler over a single-port store of RGBA texels. A write word goes
// to the store as it is accepted. A sample word runs both coordinates through
// 16 one-bit reduction steps, a finishing step and a hand-off step, then index
// and row-base math, one store read per texel (one nearest, four bilinear), a
// read wait state, a horizontal mix (bilinear only) and a final state; its
// time is bound by the bit-serial coordinate reduction and the single store
// port. One word is in flight at a time; a finished result waits in an output
// register.
`timescale 1ns / 1ps

module texture_sampler_wrap_bilinear #(
    parameter int MAX_DIM     = tsw_pkg::MAX_DIM_DEF,
    parameter int STORE_WORDS = tsw_pkg::STORE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tsw_in_if.sink                         item,
    tsw_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tsw_pkg::*;

    localparam int CW = $clog2(MAX_DIM) + 1;
    localparam int FW = $clog2(MAX_DIM) + 8;
    localparam int LW = 2 * CW + 1;
    localparam int MW = (LW > ADDR_IN_W) ? LW : ADDR_IN_W;
    localparam int AW = $clog2(STORE_WORDS);

    typedef enum logic [3:0] {
        S_IDLE, S_AXIS, S_COORD, S_BASE, S_READ, S_WAIT, S_HMIX, S_DONE
    } state_t;

    function automatic logic [AW-1:0] mod_store(input logic [MW-1:0] v);
        logic [MW-1:0] r;
        r = v;
        for (int k = MW - 1; k >= 0; k--)
        begin
            if ((64'(STORE_WORDS) << k) < (64'd1 << MW))
            begin
                if (r >= MW'(64'(STORE_WORDS) << k))
                    r = r - MW'(64'(STORE_WORDS) << k);
            end
        end
        return AW'(r);
    endfunction

    function automatic logic [CW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] r);
        if (r == '0)
            return CW'(1);
        else if (int'({23'd0, r}) > MAX_DIM)
            return CW'(MAX_DIM);
        else
            return CW'(r);
    endfunction

    // configuration
    logic [CFG_DATA_W-1:0] width_reg, height_reg, pitch_reg;
    logic [1:0]            wrap_reg;
    logic                  filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RST;
            height_reg <= DIM_RST;
            pitch_reg  <= DIM_RST;
            wrap_reg   <= WRAP_CLAMP;
            filter_reg <= FILT_NEAREST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEX_WIDTH:   width_reg  <= cfg_data;
                CFG_TEX_HEIGHT:  height_reg <= cfg_data;
                CFG_ROW_PITCH:   pitch_reg  <= cfg_data;
                CFG_WRAP_MODE:   wrap_reg   <= cfg_data[1:0];
                CFG_FILTER_MODE: filter_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_eff, h_eff, p_eff, w_m1, h_m1;
    assign w_eff = eff_dim(width_reg);
    assign h_eff = eff_dim(height_reg);
    assign p_eff = eff_dim(pitch_reg);
    assign w_m1  = w_eff - CW'(1);
    assign h_m1  = h_eff - CW'(1);

    state_t             state_reg;
    logic               accept, mem_we, mem_en, bilin;
    logic [AW-1:0]      mem_addr, rd_addr;
    logic [TEXEL_W-1:0] mem_rdata;
    tsw_axis_ctl_t      ax_ctl;
    logic               ax_done_x, ax_done_y;
    logic [FW-1:0]      fx, fy;

    assign accept = item.valid && item.ready;
    assign mem_we = accept && item.func == FUNC_WRITE;
    assign bilin  = filter_reg == FILT_BILINEAR;
    assign ax_ctl = '{start: accept && item.func == FUNC_SAMPLE, mode: wrap_reg};

    tsw_axis #(.MAX_DIM(MAX_DIM), .CW(CW), .FW(FW)) u_axis_x (
        .clk(clk), .rst_n(rst_n), .ctl(ax_ctl), .coord(item.coord_x),
        .dim(w_eff), .done(ax_done_x), .fpos(fx));

    tsw_axis #(.MAX_DIM(MAX_DIM), .CW(CW), .FW(FW)) u_axis_y (
        .clk(clk), .rst_n(rst_n), .ctl(ax_ctl), .coord(item.coord_y),
        .dim(h_eff), .done(ax_done_y), .fpos(fy));

    // texel indexes from treated coordinates
    logic [CW-1:0] x0, y0, x0c, y0c, x1c, y1c, ixr, iyr, ixc, iyc;
    logic [FW:0]   fx_rnd, fy_rnd;

    assign x0     = {1'b0, fx[FW-1:8]};
    assign y0     = {1'b0, fy[FW-1:8]};
    assign x0c    = (x0 > w_m1) ? w_m1 : x0;
    assign y0c    = (y0 > h_m1) ? h_m1 : y0;
    assign x1c    = ((x0c + CW'(1)) < w_m1) ? x0c + CW'(1) : w_m1;
    assign y1c    = ((y0c + CW'(1)) < h_m1) ? y0c + CW'(1) : h_m1;
    assign fx_rnd = {1'b0, fx} + (FW+1)'(128);
    assign fy_rnd = {1'b0, fy} + (FW+1)'(128);
    assign ixr    = fx_rnd[FW:8];
    assign iyr    = fy_rnd[FW:8];
    assign ixc    = (ixr > w_m1) ? w_m1 : ixr;
    assign iyc    = (iyr > h_m1) ? h_m1 : iyr;

    logic [CW-1:0]      col0_reg, col1_reg, row0_reg, row1_reg;
    logic [7:0]         tx_reg, ty_reg;
    logic [2*CW-1:0]    base0_reg, base1_reg;
    logic [1:0]         rd_cnt_reg, rd_tag_reg;
    logic               rd_valid_reg, out_valid_reg;
    logic [TEXEL_W-1:0] tex_reg [4];
    logic [TEXEL_W-1:0] h0_reg, h1_reg, px_reg, h0_next, h1_next, v_next;
    logic [LW-1:0]      lin;

    assign lin      = LW'(rd_cnt_reg[1] ? base1_reg : base0_reg)
                    + LW'(rd_cnt_reg[0] ? col1_reg : col0_reg);
    assign rd_addr  = mod_store(MW'(lin));
    assign mem_en   = mem_we || state_reg == S_READ;
    assign mem_addr = mem_we ? mod_store(MW'(item.write_addr)) : rd_addr;

    tsw_store #(.DEPTH(STORE_WORDS), .AW(AW)) u_store (
        .clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
        .wdata(item.texel_rgba), .rdata(mem_rdata));

    tsw_lerp u_lerp_top (.a(tex_reg[0]), .b(tex_reg[1]), .t(tx_reg), .y(h0_next));
    tsw_lerp u_lerp_bot (.a(tex_reg[2]), .b(tex_reg[3]), .t(tx_reg), .y(h1_next));
    tsw_lerp u_lerp_ver (.a(h0_reg), .b(h1_reg), .t(ty_reg), .y(v_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            rd_tag_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the done state reloads the output register itself
            if (out_valid_reg && result.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            rd_valid_reg <= 1'b0;
            if (rd_valid_reg)
                tex_reg[rd_tag_reg] <= mem_rdata;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.func == FUNC_SAMPLE)
                        state_reg <= S_AXIS;
                end
                S_AXIS:
                begin
                    if (ax_done_x)
                        state_reg <= S_COORD;
                end
                S_COORD:
                begin
                    col0_reg  <= bilin ? x0c : ixc;
                    row0_reg  <= bilin ? y0c : iyc;
                    col1_reg  <= x1c;
                    row1_reg  <= y1c;
                    tx_reg    <= fx[7:0];
                    ty_reg    <= fy[7:0];
                    state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    base0_reg  <= (2*CW)'(row0_reg) * (2*CW)'(p_eff);
                    base1_reg  <= (2*CW)'(row1_reg) * (2*CW)'(p_eff);
                    rd_cnt_reg <= '0;
                    state_reg  <= S_READ;
                end
                S_READ:
                begin
                    rd_valid_reg <= 1'b1;
                    rd_tag_reg   <= rd_cnt_reg;
                    rd_cnt_reg   <= rd_cnt_reg + 2'd1;
                    if (!bilin || rd_cnt_reg == 2'd3)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    state_reg <= bilin ? S_HMIX : S_DONE;
                end
                S_HMIX:
                begin
                    h0_reg    <= h0_next;
                    h1_reg    <= h1_next;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        px_reg        <= bilin ? v_next : tex_reg[0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign item.ready   = state_reg == S_IDLE;
    assign result.valid = out_valid_reg;
    assign result.red   = px_reg[0*CH_W +: CH_W];
    assign result.green = px_reg[1*CH_W +: CH_W];
    assign result.blue  = px_reg[2*CH_W +: CH_W];
    assign result.alpha = px_reg[3*CH_W +: CH_W];

    a_axes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        ax_done_x |-> ax_done_y)
        else $error("coordinate units out of step");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_IDLE)
        else $error("store write during a sample");

    a_read_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_READ || state_reg == S_WAIT))
        else $error("store read data returned outside the read window");

endmodule
